@@ rtl/fsc_pkg.sv @@
// Shared types and constants of the feedback sensor change decoder.
// Used by the parser, the sensor store, the change emitter and the top level.
package fsc_pkg;

  // Number of eight-bit feedback modules kept in the sensor store.
  localparam int unsigned MODULE_COUNT = 64;
  localparam int unsigned ADDR_W       = (MODULE_COUNT > 1) ? $clog2(MODULE_COUNT) : 1;
  // Module index range reachable from a reply (pair base plus one).
  localparam int unsigned MOD_W        = 9;
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned PIN_W        = 10;
  localparam int unsigned POS_W        = 4;

  // Parse phase of the reply.
  typedef enum logic [1:0] {
    PH_MODULE = 2'd0,
    PH_DATA0  = 2'd1,
    PH_DATA1  = 2'd2,
    PH_DONE   = 2'd3
  } phase_e;

  // Store access requested by one accepted byte.
  typedef struct packed {
    logic              hit;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] data;
  } req_t;

  // A module byte that changed, with the mask of changed bits.
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] data;
    logic [BYTE_W-1:0] mask;
  } item_t;

endpackage

@@ rtl/fsc_parser.sv @@
// Reply parser: tracks the parse phase and the module pair base.
// Depends on fsc_pkg for the phase enum and the store request struct.
module fsc_parser
  import fsc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [BYTE_W-1:0] byte_i,
  input  logic              start_i,
  output req_t              req_o
);

  phase_e           phase_q, phase_d;
  phase_e           phase_cur;
  logic [MOD_W-1:0] base_q, base_d;
  logic [MOD_W-1:0] module_idx;
  logic [BYTE_W-1:0] byte_m1;

  // A start flag restarts parsing with this byte.
  assign phase_cur = start_i ? PH_MODULE : phase_q;
  assign byte_m1   = byte_i - BYTE_W'(1);

  // Next phase and pair base.
  always_comb begin
    phase_d = phase_q;
    base_d  = base_q;
    if (accept_i) begin
      case (phase_cur)
        PH_MODULE: begin
          if (byte_i == '0) begin
            phase_d = PH_DONE;
          end else begin
            phase_d = PH_DATA0;
            base_d  = {byte_m1, 1'b0};
          end
        end
        PH_DATA0: phase_d = PH_DATA1;
        PH_DATA1: phase_d = PH_MODULE;
        default:  phase_d = PH_DONE;
      endcase
    end
  end

  // The pair base is even, so the second module just sets bit zero.
  assign module_idx = (phase_cur == PH_DATA1) ? {base_q[MOD_W-1:1], 1'b1} : base_q;

  // Store request for data bytes that land inside the store.
  always_comb begin
    req_o.hit  = ((phase_cur == PH_DATA0) || (phase_cur == PH_DATA1)) &&
                 ({1'b0, module_idx} < (MOD_W+1)'(MODULE_COUNT));
    req_o.addr = module_idx[ADDR_W-1:0];
    req_o.data = byte_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_MODULE;
      base_q  <= '0;
    end else begin
      phase_q <= phase_d;
      base_q  <= base_d;
    end
  end

endmodule

@@ rtl/fsc_store.sv @@
// Sensor store: module byte memory with read-modify-write and forwarding.
// Depends on fsc_pkg; hands changed bytes to the change emitter.
module fsc_store
  import fsc_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  accept_i,
  input  req_t  req_i,
  output logic  ready_o,
  output logic  push_o,
  output item_t item_o,
  input  logic  emit_ready_i
);

  logic [BYTE_W-1:0]       mem_q [MODULE_COUNT];
  logic [MODULE_COUNT-1:0] vld_q;
  logic                    a_valid_q;
  logic [ADDR_W-1:0]       a_addr_q;
  logic [BYTE_W-1:0]       a_data_q;
  logic [BYTE_W-1:0]       rd_q;
  logic                    rv_q;
  logic                    fwd_q;
  logic [BYTE_W-1:0]       fwd_data_q;
  logic [BYTE_W-1:0]       old_byte;
  logic [BYTE_W-1:0]       diff;
  logic                    retire;
  logic                    rd_en;
  logic                    same_entry;

  // Old byte: forwarded write, stored byte, or zero for an entry never written.
  assign old_byte = fwd_q ? fwd_data_q : (rv_q ? rd_q : '0);
  assign diff     = old_byte ^ a_data_q;

  // The stage retires when unchanged or when the emitter takes it.
  assign retire     = a_valid_q && ((diff == '0) || emit_ready_i);
  assign ready_o    = !a_valid_q || retire;
  assign rd_en      = accept_i && req_i.hit;
  assign same_entry = retire && (a_addr_q == req_i.addr);

  assign push_o      = retire && (diff != '0);
  assign item_o.addr = a_addr_q;
  assign item_o.data = a_data_q;
  assign item_o.mask = diff;

  // Memory write on retire and registered read on accept.
  always_ff @(posedge clk_i) begin
    if (retire) begin
      mem_q[a_addr_q] <= a_data_q;
    end
    if (rd_en) begin
      rd_q       <= mem_q[req_i.addr];
      fwd_data_q <= a_data_q;
    end
  end

  // Per-entry written flags and the read stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      a_valid_q <= 1'b0;
      a_addr_q  <= '0;
      a_data_q  <= '0;
      rv_q      <= 1'b0;
      fwd_q     <= 1'b0;
    end else begin
      if (retire) begin
        vld_q[a_addr_q] <= 1'b1;
      end
      if (rd_en) begin
        rv_q     <= vld_q[req_i.addr];
        fwd_q    <= same_entry;
        a_addr_q <= req_i.addr;
        a_data_q <= req_i.data;
      end
      if (ready_o) begin
        a_valid_q <= rd_en;
      end
    end
  end

`ifndef ASSERT_OFF
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_valid_q && !retire |=> a_valid_q && $stable(a_addr_q) && $stable(a_data_q))
    else $error("read stage changed while stalled");
  push_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> emit_ready_i && a_valid_q)
    else $error("change pushed to a busy emitter");
`endif

endmodule

@@ rtl/fsc_emitter.sv @@
// Change emitter: sends one changed pin per cycle while the output is ready, most significant bit first.
// Depends on fsc_pkg for the changed-byte item struct.
module fsc_emitter
  import fsc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  item_t            item_i,
  output logic             ready_o,
  output logic             valid_o,
  input  logic             take_i,
  output logic [PIN_W-1:0] pin_o,
  output logic             level_o,
  output logic             last_o
);

  logic              b_valid_q;
  logic [ADDR_W-1:0] addr_q;
  logic [BYTE_W-1:0] data_q;
  logic [BYTE_W-1:0] mask_q, mask_d;
  logic [BYTE_W-1:0] top_bit;
  logic [2:0]        top_idx;
  logic [POS_W-1:0]  pos;
  logic              done;

  // Pick the highest changed bit still pending.
  always_comb begin
    top_idx = '0;
    top_bit = '0;
    for (int i = 0; i < BYTE_W; i++) begin
      if (mask_q[i]) begin
        top_idx = 3'(i);
      end
    end
    top_bit[top_idx] = 1'b1;
  end

  // Bit seven is position one, bit zero is position eight.
  assign pos     = POS_W'(BYTE_W) - POS_W'(top_idx);
  assign mask_d  = mask_q & ~top_bit;
  assign last_o  = (mask_d == '0);
  assign level_o = data_q[top_idx];
  assign pin_o   = PIN_W'({addr_q, 3'b000}) + PIN_W'(pos);
  assign valid_o = b_valid_q;
  assign done    = take_i && last_o;
  assign ready_o = !b_valid_q || done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      addr_q    <= '0;
      data_q    <= '0;
      mask_q    <= '0;
    end else begin
      if (push_i) begin
        b_valid_q <= 1'b1;
        addr_q    <= item_i.addr;
        data_q    <= item_i.data;
        mask_q    <= item_i.mask;
      end else if (take_i) begin
        mask_q <= mask_d;
        if (last_o) begin
          b_valid_q <= 1'b0;
        end
      end
    end
  end

`ifndef ASSERT_OFF
  mask_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_valid_q |-> mask_q != '0)
    else $error("emitter holds an empty change mask");
  one_per_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i && !last_o |=> b_valid_q &&
      ($countones(mask_q) + 1 == $countones($past(mask_q))))
    else $error("emitter did not retire exactly one change");
`endif

endmodule

@@ rtl/feedback_sensor_change_decoder.sv @@
// Feedback sensor change decoder: top level joining parser, store and emitter.
// Latency: a changed byte is registered in the store's read stage and then in the emitter before its first pin.
// Throughput: one byte per cycle while the store is not stalled; a byte with k changed bits holds the emitter
// until its k pins are sent, one pin per cycle while the output is ready, which sets the sustained rate.
// Reset: asynchronous, active low; the parser expects a module number and the
// store reads as all zero through per-module written flags, with no clearing pass.
module feedback_sensor_change_decoder
  import fsc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] reply_byte
  input  logic        s_axis_tuser_i,   // [0] reply_start
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [9:0] pin_number, [10] pin_level, zero fill
  output logic        m_axis_tlast_o    // last_change
);

  req_t             req;
  item_t            item;
  logic             accept;
  logic             push;
  logic             emit_ready;
  logic             take;
  logic [PIN_W-1:0] pin;
  logic             level;

  // Transactions on both sides.
  assign accept = s_axis_tvalid_i && s_axis_tready_o;
  assign take   = m_axis_tvalid_o && m_axis_tready_i;

  fsc_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (s_axis_tdata_i),
    .start_i  (s_axis_tuser_i),
    .req_o    (req)
  );

  fsc_store u_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .req_i        (req),
    .ready_o      (s_axis_tready_o),
    .push_o       (push),
    .item_o       (item),
    .emit_ready_i (emit_ready)
  );

  fsc_emitter u_emitter (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (item),
    .ready_o (emit_ready),
    .valid_o (m_axis_tvalid_o),
    .take_i  (take),
    .pin_o   (pin),
    .level_o (level),
    .last_o  (m_axis_tlast_o)
  );

  // Pack the result fields, lowest first.
  assign m_axis_tdata_o = {5'b0, level, pin};

endmodule

@@ bench/tb_feedback_sensor_change_decoder.sv @@
// Self-checking bench for the feedback sensor change decoder: streams reply bytes,
// predicts every changed pin and compares each result transaction in order.
// Depends on fsc_pkg and the feedback_sensor_change_decoder top level only.
`timescale 1ns / 1ps

module tb_feedback_sensor_change_decoder
  import fsc_pkg::*;
();

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned RANDOM_ITEMS = 70;

  // One reply byte as offered on the slave side.
  typedef struct packed {
    logic [7:0] byte_val;
    logic       start;
  } reply_byte_t;

  // One predicted pin change.
  typedef struct packed {
    logic [PIN_W-1:0] pin;
    logic             level;
    logic             last;
  } pin_change_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = '0;  // [7:0] reply_byte
  logic        s_axis_tuser_i = 1'b0; // [0] reply_start
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [15:0] m_axis_tdata_o;       // [9:0] pin_number, [10] pin_level, zero fill
  logic        m_axis_tlast_o;

  reply_byte_t pending_bytes[$];
  pin_change_t expected_changes[$];

  // Private copy of the parser state and the sensor store.
  phase_e      pred_phase;
  int unsigned pred_base;
  logic [7:0]  pred_store [MODULE_COUNT];

  int unsigned bytes_accepted = 0;
  int unsigned error_count = 0;
  int unsigned stall_cycles = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;
  logic        byte_taken = 1'b0;

  feedback_sensor_change_decoder u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // Clock generation.
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Neither side idles in the middle stretch of the run.
  function automatic logic quiet_stretch();
    return (bytes_accepted >= 60) && (bytes_accepted < 95);
  endfunction

  // Compare one data byte with its stored module byte and queue the changed pins.
  task automatic queue_module_changes(input int unsigned module_idx, input logic [7:0] data);
    logic [7:0]  diff;
    pin_change_t change;
    int          last_idx;
    if (module_idx < MODULE_COUNT) begin
      diff = pred_store[module_idx] ^ data;
      pred_store[module_idx] = data;
      last_idx = -1;
      for (int pos = 1; pos <= 8; pos++) begin
        if (diff[8-pos]) begin
          change.pin   = PIN_W'(module_idx * 8 + pos);
          change.level = data[8-pos];
          change.last  = 1'b0;
          expected_changes.push_back(change);
          last_idx = expected_changes.size() - 1;
        end
      end
      if (last_idx >= 0) begin
        expected_changes[last_idx].last = 1'b1;
      end
    end
  endtask

  // Advance the parser by one accepted reply byte.
  task automatic predict_reply_byte(input logic [7:0] byte_val, input logic start);
    if (start) begin
      pred_phase = PH_MODULE;
    end
    case (pred_phase)
      PH_MODULE: begin
        if (byte_val == 8'd0) begin
          pred_phase = PH_DONE;
        end else begin
          pred_base  = ((byte_val - 1) << 1) & 9'h1FF;
          pred_phase = PH_DATA0;
        end
      end
      PH_DATA0: begin
        queue_module_changes(pred_base, byte_val);
        pred_phase = PH_DATA1;
      end
      PH_DATA1: begin
        queue_module_changes(pred_base + 1, byte_val);
        pred_phase = PH_MODULE;
      end
      default: begin
      end
    endcase
  endtask

  task automatic push_byte(input logic [7:0] byte_val, input logic start);
    reply_byte_t item;
    item.byte_val = byte_val;
    item.start    = start;
    pending_bytes.push_back(item);
  endtask

  // Module-pair numbers mostly hit a few low modules so that bytes keep changing.
  function automatic logic [7:0] pick_pair_number();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) begin
      return 8'($urandom_range(3, 1));
    end else if (r < 90) begin
      return 8'($urandom_range(32, 4));
    end
    return 8'($urandom_range(255, 33));
  endfunction

  // Slave-side driver: hold an offered byte until its transaction completes.
  always @(negedge clk_i) begin
    reply_byte_t item;
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else if (s_axis_tvalid_i && !byte_taken) begin
      s_axis_tvalid_i <= 1'b1;
    end else if (pending_bytes.size() > 0 && (quiet_stretch() || $urandom_range(99) >= 32)) begin
      item = pending_bytes.pop_front();
      s_axis_tdata_i  <= item.byte_val;
      s_axis_tuser_i  <= item.start;
      s_axis_tvalid_i <= 1'b1;
    end else begin
      s_axis_tvalid_i <= 1'b0;
    end
  end

  // Master-side ready: random idling, one long hold-off, and a quiet stretch.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else if (hold_left > 0) begin
      m_axis_tready_i <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && bytes_accepted >= 30) begin
      m_axis_tready_i <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      m_axis_tready_i <= quiet_stretch() || ($urandom_range(99) >= 32);
    end
  end

  // Input monitor: predict on each accepted byte transaction.
  always @(posedge clk_i) begin
    byte_taken <= s_axis_tvalid_i && s_axis_tready_o;
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) begin
      predict_reply_byte(s_axis_tdata_i, s_axis_tuser_i);
      bytes_accepted <= bytes_accepted + 1;
    end
  end

  // Output monitor: check each result transaction against the oldest prediction.
  always @(posedge clk_i) begin
    pin_change_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_changes.size() == 0) begin
        error_count += 1;
        $display("%0t: unexpected change pin=%0d level=%0b last=%0b", $realtime,
                 m_axis_tdata_o[9:0], m_axis_tdata_o[10], m_axis_tlast_o);
      end else begin
        want = expected_changes.pop_front();
        if (m_axis_tdata_o[9:0] !== want.pin) begin
          error_count += 1;
          $display("%0t: pin_number expected %0d actual %0d", $realtime, want.pin,
                   m_axis_tdata_o[9:0]);
        end
        if (m_axis_tdata_o[10] !== want.level) begin
          error_count += 1;
          $display("%0t: pin_level of pin %0d expected %0b actual %0b", $realtime,
                   want.pin, want.level, m_axis_tdata_o[10]);
        end
        if (m_axis_tlast_o !== want.last) begin
          error_count += 1;
          $display("%0t: last_change of pin %0d expected %0b actual %0b", $realtime,
                   want.pin, want.last, m_axis_tlast_o);
        end
      end
    end
  end

  // Watchdog: count cycles with work pending and no transaction on either side.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
        stall_cycles <= 0;
      end else if (pending_bytes.size() > 0 || s_axis_tvalid_i
                   || expected_changes.size() > 0) begin
        stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("RESULT: ERROR");
          $finish;
        end
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    int unsigned random_count;
    int unsigned frames;
    int unsigned r;
    pred_phase = PH_MODULE;
    pred_base  = 0;
    for (int i = 0; i < MODULE_COUNT; i++) begin
      pred_store[i] = 8'h00;
    end

    // Directed part: all bits set and cleared, top of the store, modules
    // beyond the store, end of reply, ignored bytes and a restart mid-frame.
    push_byte(8'd1, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'd32, 1'b0);
    push_byte(8'h81, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'd33, 1'b0);
    push_byte(8'hAA, 1'b0);
    push_byte(8'h55, 1'b0);
    push_byte(8'd255, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'd1, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h5A, 1'b0);
    push_byte(8'd0, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h37, 1'b0);
    push_byte(8'd2, 1'b1);
    push_byte(8'h3C, 1'b0);
    push_byte(8'd1, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'hA5, 1'b0);
    push_byte(8'd0, 1'b0);

    // Random part: mostly well-formed replies, some cut short, some noise.
    random_count = 0;
    while (random_count < RANDOM_ITEMS) begin
      r = $urandom_range(99);
      if (r < 80) begin
        frames = $urandom_range(4, 1);
        for (int f = 0; f < frames; f++) begin
          push_byte(pick_pair_number(), (f == 0));
          push_byte(8'($urandom_range(255)), 1'b0);
          push_byte(8'($urandom_range(255)), 1'b0);
          random_count += 3;
        end
        push_byte(8'd0, 1'b0);
        random_count += 1;
        // Bytes after the end of a reply are ignored by the block.
        repeat ($urandom_range(2)) push_byte(8'($urandom_range(255)), 1'b0);
      end else if (r < 90) begin
        push_byte(pick_pair_number(), 1'b1);
        push_byte(8'($urandom_range(255)), 1'b0);
        random_count += 2;
      end else begin
        push_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
        random_count += 1;
      end
    end

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_bytes.size() > 0 || s_axis_tvalid_i || expected_changes.size() > 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (error_count == 0 && expected_changes.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/fsc_pkg.sv
rtl/fsc_parser.sv
rtl/fsc_store.sv
rtl/fsc_emitter.sv
rtl/feedback_sensor_change_decoder.sv
bench/tb_feedback_sensor_change_decoder.sv
